FILE: rtl/conv_gemm_mac_tile_defines.svh
// Assertion macros shared by the MAC tile RTL.
// Both expect clk in the including scope; CGM_ASSERT also expects rst.
`ifndef CONV_GEMM_MAC_TILE_DEFINES_SVH
`define CONV_GEMM_MAC_TILE_DEFINES_SVH

// Checked outside reset only.
`define CGM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CGM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cgm_pkg.sv
// Types, widths and saturation helper for the convolution MAC tile.
// No dependencies; used by the channel interfaces and the top level.
package cgm_pkg;

  localparam int IO_LANES = 8;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = 48;
  localparam int BIAS_W   = 32;
  localparam int IDX_W    = $clog2(IO_LANES);

  typedef logic signed [DATA_W-1:0] data16_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [BIAS_W-1:0] bias_t;
  typedef logic signed [ACC_W:0]    wide_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Clamp a sum that is one bit wider than the accumulator.
  function automatic acc_t sat48(input wide_t v);
    acc_t r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/cgm_in_if.sv
// Input channel of the MAC tile: one activation, eight weights, last flag.
// Depends on cgm_pkg.
interface cgm_in_if;
  import cgm_pkg::*;

  logic    valid;
  logic    ready;
  data16_t activation;
  data16_t weight0;
  data16_t weight1;
  data16_t weight2;
  data16_t weight3;
  data16_t weight4;
  data16_t weight5;
  data16_t weight6;
  data16_t weight7;
  logic    last_term;

  modport source (
    output valid, activation, weight0, weight1, weight2, weight3,
           weight4, weight5, weight6, weight7, last_term,
    input  ready
  );
  modport sink (
    input  valid, activation, weight0, weight1, weight2, weight3,
           weight4, weight5, weight6, weight7, last_term,
    output ready
  );
endinterface

FILE: rtl/cgm_out_if.sv
// Result channel of the MAC tile: eight saturated Q32.16 lane sums.
// Depends on cgm_pkg.
interface cgm_out_if;
  import cgm_pkg::*;

  logic valid;
  logic ready;
  acc_t result0;
  acc_t result1;
  acc_t result2;
  acc_t result3;
  acc_t result4;
  acc_t result5;
  acc_t result6;
  acc_t result7;

  modport source (
    output valid, result0, result1, result2, result3,
           result4, result5, result6, result7,
    input  ready
  );
  modport sink (
    input  valid, result0, result1, result2, result3,
           result4, result5, result6, result7,
    output ready
  );
endinterface

FILE: rtl/conv_gemm_mac_tile.sv
// Eight-lane im2col GEMM multiply-accumulate tile, top level.
// Depends on cgm_pkg, cgm_in_if, cgm_out_if and conv_gemm_mac_tile_defines.svh.
//
// Usage:
//  - feed carries one Q8.8 activation with one Q8.8 weight per lane. Each
//    transaction adds activation*weight into that lane's 48-bit Q32.16
//    accumulator, saturating at the signed 48-bit range.
//  - A transaction with last_term set closes the reduction: the lane sums
//    plus the bias registers (saturated) go out as one transaction on
//    result, and the accumulators restart from zero. Other transactions
//    produce nothing on result.
//  - Bias registers are written through wr_en/wr_index/wr_data; the user must
//    only write while the tile is idle (unenforced); lanes >= LANES give zero.
//  - Throughput: one feed transaction per cycle while feed.ready is high. Four
//    register stages (input, product, accumulate, bias/output); a last_term
//    transaction passes through all four before its result is valid.
//  - When result is stalled, the stages behind the output register keep
//    filling; feed.ready drops only once a finished sum is also waiting in
//    the accumulate stage and a last_term item reaches it.
//  - Synchronous reset empties the pipeline and clears accumulators and
//    bias registers.
`include "conv_gemm_mac_tile_defines.svh"

module conv_gemm_mac_tile #(
  parameter int LANES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  cgm_in_if.sink                     feed,
  cgm_out_if.source                  result,
  input  logic                       wr_en,
  input  logic [cgm_pkg::IDX_W-1:0]  wr_index,
  input  logic [cgm_pkg::BIAS_W-1:0] wr_data
);
  import cgm_pkg::*;

  localparam int ACC_LANES = (LANES < IO_LANES) ? LANES : IO_LANES;

  // Stage valids and handshake
  logic v1, v2, v3, ov;
  logic out_go, s3_go, s2_go, s1_go;
  logic s2_fire, ov_load;

  data16_t act1;
  logic    last1, last2;
  data16_t weights [IO_LANES];
  acc_t    res_lane [IO_LANES];
  logic [IO_LANES-1:0] zero_lane;
  logic    acc_all_zero;

  assign weights[0] = feed.weight0;
  assign weights[1] = feed.weight1;
  assign weights[2] = feed.weight2;
  assign weights[3] = feed.weight3;
  assign weights[4] = feed.weight4;
  assign weights[5] = feed.weight5;
  assign weights[6] = feed.weight6;
  assign weights[7] = feed.weight7;

  // Items without last_term retire in the accumulate stage, so only
  // last_term items wait on the stages downstream.
  assign out_go  = !ov || result.ready;
  assign s3_go   = !v3 || out_go;
  assign s2_go   = !v2 || !last2 || s3_go;
  assign s1_go   = !v1 || s2_go;
  assign s2_fire = v2 && s2_go;
  assign ov_load = v3 && out_go;

  assign feed.ready = s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (s1_go) v1 <= feed.valid;
      if (s2_go) v2 <= v1;
      if (s3_go) v3 <= v2 && last2;
      if (out_go) ov <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      act1  <= feed.activation;
      last1 <= feed.last_term;
    end
    if (s2_go) last2 <= last1;
  end

  for (genvar l = 0; l < IO_LANES; l++) begin : g_lane
    if (l < ACC_LANES) begin : g_act
      data16_t w1;
      prod_t   prod2;
      acc_t    acc;
      acc_t    acc_sum;
      acc_t    sum3;
      acc_t    res;
      bias_t   bias;

      assign acc_sum = sat48({acc[ACC_W-1], acc} +
                             {{(ACC_W+1-PROD_W){prod2[PROD_W-1]}}, prod2});

      always_ff @(posedge clk) begin
        if (rst) begin
          bias <= '0;
        end else if (wr_en && wr_index == IDX_W'(l)) begin
          bias <= wr_data;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          acc <= '0;
        end else if (s2_fire) begin
          acc <= last2 ? '0 : acc_sum;
        end
      end

      always_ff @(posedge clk) begin
        if (s1_go) w1 <= weights[l];
        if (s2_go) prod2 <= act1 * w1;
        if (s2_fire && last2) sum3 <= acc_sum;
        if (ov_load) begin
          res <= sat48({sum3[ACC_W-1], sum3} +
                       {{(ACC_W+1-BIAS_W){bias[BIAS_W-1]}}, bias});
        end
      end

      assign res_lane[l]  = res;
      assign zero_lane[l] = (acc == '0);
    end else begin : g_idle
      assign res_lane[l]  = '0;
      assign zero_lane[l] = 1'b1;
    end
  end

  assign acc_all_zero = &zero_lane;

  assign result.valid   = ov;
  assign result.result0 = res_lane[0];
  assign result.result1 = res_lane[1];
  assign result.result2 = res_lane[2];
  assign result.result3 = res_lane[3];
  assign result.result4 = res_lane[4];
  assign result.result5 = res_lane[5];
  assign result.result6 = res_lane[6];
  assign result.result7 = res_lane[7];

  `CGM_ASSERT(a_acc_clear, s2_fire && last2 |=> acc_all_zero, "accumulators not cleared after last term")
  `CGM_ASSERT(a_sum_to_out, v3 && out_go |=> ov, "finished sum lost on its way to the output")
  `CGM_ASSERT(a_sum_hold, v3 && !out_go |=> v3, "finished sum dropped while output stalled")
  `CGM_ASSERT(a_empty_ready, !v1 && !v2 && !v3 && !ov |-> feed.ready, "empty tile refuses input")
  `CGM_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !ov && !v3, "result pending right after reset")

endmodule

FILE: bench/conv_gemm_mac_tile_sum_check.sv
// Passive lane-sum predictor and result comparator for the MAC tile bench.
// Watches the feed and result channels and the bias write port.
// Depends on cgm_pkg, cgm_in_if and cgm_out_if.
module conv_gemm_mac_tile_sum_check #(
  parameter int LANES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  cgm_in_if                          feed,
  cgm_out_if                         result,
  input  logic                       wr_en,
  input  logic [cgm_pkg::IDX_W-1:0]  wr_index,
  input  logic [cgm_pkg::BIAS_W-1:0] wr_data,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cgm_pkg::*;

  localparam longint SUM_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef acc_t [IO_LANES-1:0] lane_vec_t;

  longint    lane_acc  [IO_LANES];
  longint    lane_bias [IO_LANES];
  lane_vec_t sums_q [$];
  int        fails = 0;
  int        n_pending = 0;

  assign fail_count = fails;
  assign pending    = n_pending;

  function automatic acc_t sat_q16(input longint v);
    if (v > SUM_HI) return acc_t'(SUM_HI);
    if (v < SUM_LO) return acc_t'(SUM_LO);
    return acc_t'(v);
  endfunction

  task automatic report(input string msg);
    // keep the log short if the tile is badly broken
    if (fails < 100) $display("MISMATCH @%0t: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    lane_vec_t got;
    lane_vec_t want;
    data16_t   wts [IO_LANES];
    if (rst) begin
      for (int i = 0; i < IO_LANES; i++) begin
        lane_acc[i]  = 0;
        lane_bias[i] = 0;
      end
      sums_q.delete();
    end else begin
      if (wr_en) lane_bias[wr_index] = longint'(bias_t'(wr_data));

      // compare before predicting, so a result can never match its own item
      if (result.valid && result.ready) begin
        got = {result.result7, result.result6, result.result5, result.result4,
               result.result3, result.result2, result.result1, result.result0};
        if (sums_q.size() == 0) begin
          report("result transaction with no lane sums pending");
        end else begin
          want = sums_q.pop_front();
          for (int i = 0; i < IO_LANES; i++) begin
            if (got[i] !== want[i])
              report($sformatf("lane %0d sum: got %0d, expected %0d",
                               i, $signed(got[i]), $signed(want[i])));
          end
        end
      end

      if (feed.valid && feed.ready) begin
        wts[0] = feed.weight0;
        wts[1] = feed.weight1;
        wts[2] = feed.weight2;
        wts[3] = feed.weight3;
        wts[4] = feed.weight4;
        wts[5] = feed.weight5;
        wts[6] = feed.weight6;
        wts[7] = feed.weight7;
        for (int i = 0; i < LANES && i < IO_LANES; i++)
          lane_acc[i] = sat_q16(lane_acc[i] +
                                longint'(feed.activation) * longint'(wts[i]));
        if (feed.last_term) begin
          // lanes beyond LANES have no accumulator and read as zero
          for (int i = 0; i < IO_LANES; i++)
            want[i] = (i < LANES) ? sat_q16(lane_acc[i] + lane_bias[i]) : '0;
          sums_q.push_back(want);
          for (int i = 0; i < IO_LANES; i++) lane_acc[i] = 0;
        end
      end
    end
    n_pending = sums_q.size();
  end

endmodule

FILE: bench/conv_gemm_mac_tile_tb.sv
// Top of the MAC tile bench: clock, reset, bias writes, feed and result traffic.
// Depends on cgm_pkg, cgm_in_if, cgm_out_if, conv_gemm_mac_tile and
// conv_gemm_mac_tile_sum_check.
module conv_gemm_mac_tile_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cgm_pkg::*;

  localparam int          TILE_LANES   = 8;
  localparam int unsigned CYCLE_LIMIT  = 50_000;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          FLUSH_CYCLES = 8;
  // full-scale products in one long reduction
  localparam int          SAT_TERMS    = 40;

  localparam data16_t Q_MAX    = 16'sh7FFF;
  localparam data16_t Q_MIN    = 16'sh8000;
  localparam bias_t   BIAS_MAX = 32'sh7FFF_FFFF;
  localparam bias_t   BIAS_MIN = 32'sh8000_0000;

  typedef enum logic [IDX_W-1:0] {
    BIAS_LANE0, BIAS_LANE1, BIAS_LANE2, BIAS_LANE3,
    BIAS_LANE4, BIAS_LANE5, BIAS_LANE6, BIAS_LANE7
  } bias_reg_e;

  typedef data16_t [IO_LANES-1:0] weight_vec_t;
  typedef struct packed {
    data16_t     act;
    weight_vec_t w;
    logic        last;
  } mac_term_t;
  typedef bias_t bias_set_t [IO_LANES];

  logic               clk = 1'b0;
  logic               rst;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_index;
  logic [BIAS_W-1:0]  wr_data;
  int                 fail_count;
  int                 pending;
  int unsigned        cycle_cnt = 0;
  int                 hold_seq = 0;
  logic               sink_stalls = 1'b1;
  bit                 src_gaps = 1'b1;

  cgm_in_if  feed ();
  cgm_out_if result ();

  conv_gemm_mac_tile #(.LANES(TILE_LANES)) DUT (
    .clk      (clk),
    .rst      (rst),
    .feed     (feed),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  conv_gemm_mac_tile_sum_check #(.LANES(TILE_LANES)) sum_check (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed),
    .result     (result),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("conv_gemm_mac_tile test failed");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off each time hold_seq moves.
  initial begin
    int seen_hold;
    int hold_left;
    seen_hold = 0;
    hold_left = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= !sink_stalls || ($urandom_range(99) >= 11);
      end
    end
  end

  function automatic data16_t rand_q88();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return data16_t'(int'($urandom_range(512)) - 256);
      default: return data16_t'($urandom);
    endcase
  endfunction

  function automatic mac_term_t rand_term(input logic last);
    mac_term_t t;
    t.act = rand_q88();
    for (int i = 0; i < IO_LANES; i++) t.w[i] = rand_q88();
    t.last = last;
    return t;
  endfunction

  function automatic mac_term_t term_of(input data16_t act, input weight_vec_t w,
                                        input logic last);
    mac_term_t t;
    t.act  = act;
    t.w    = w;
    t.last = last;
    return t;
  endfunction

  task automatic send_term(input mac_term_t t);
    while (src_gaps && $urandom_range(99) < 11) begin
      feed.valid <= 1'b0;
      @(posedge clk);
    end
    feed.valid      <= 1'b1;
    feed.activation <= t.act;
    feed.weight0    <= t.w[0];
    feed.weight1    <= t.w[1];
    feed.weight2    <= t.w[2];
    feed.weight3    <= t.w[3];
    feed.weight4    <= t.w[4];
    feed.weight5    <= t.w[5];
    feed.weight6    <= t.w[6];
    feed.weight7    <= t.w[7];
    feed.last_term  <= t.last;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
  endtask

  // Stop feeding until every sum is out, then let the pipeline empty.
  task automatic drain();
    feed.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic load_biases(input bias_set_t b);
    for (int i = 0; i < IO_LANES; i++) begin
      wr_en    <= 1'b1;
      wr_index <= bias_reg_e'(BIAS_LANE0 + i);
      wr_data  <= b[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  // Reductions of random length, mostly short, now and then long.
  task automatic run_reductions(input int n_terms);
    int sent;
    int len;
    sent = 0;
    while (sent < n_terms) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(4, 1);
        6, 7, 8:          len = $urandom_range(16, 5);
        default:          len = $urandom_range(48, 17);
      endcase
      for (int k = 0; k < len; k++) send_term(rand_term(k == len - 1));
      sent += len;
    end
  endtask

  initial begin
    bias_set_t bset;
    feed.valid      <= 1'b0;
    feed.activation <= '0;
    feed.weight0    <= '0;
    feed.weight1    <= '0;
    feed.weight2    <= '0;
    feed.weight3    <= '0;
    feed.weight4    <= '0;
    feed.weight5    <= '0;
    feed.weight6    <= '0;
    feed.weight7    <= '0;
    feed.last_term  <= 1'b0;
    wr_en           <= 1'b0;
    wr_index        <= '0;
    wr_data         <= '0;
    rst             <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed terms with the reset biases of zero; weights listed lane 7 first
    send_term(term_of(Q_MAX, {16'sd256, 16'shAAAA, 16'sh5555, 16'shFFFF,
                              16'sd1, 16'sd0, Q_MIN, Q_MAX}, 1'b1));
    send_term(term_of(Q_MIN, {16'shFF00, 16'sh5555, 16'shAAAA, 16'sd0,
                              16'sd1, 16'shFFFF, Q_MAX, Q_MIN}, 1'b1));
    send_term(term_of(16'sd0, {IO_LANES{Q_MAX}}, 1'b1));
    send_term(term_of(16'shFFFF, {IO_LANES{Q_MIN}}, 1'b0));
    send_term(term_of(16'sd256, {16'sd8, 16'sd7, 16'sd6, 16'sd5,
                                 16'sd4, 16'sd3, 16'sd2, 16'sd1}, 1'b0));
    send_term(term_of(16'shFF00, {IO_LANES{Q_MAX}}, 1'b1));
    send_term(term_of(Q_MIN, {IO_LANES{Q_MIN}}, 1'b0));
    send_term(term_of(Q_MIN, {IO_LANES{Q_MIN}}, 1'b0));
    send_term(term_of(Q_MAX, {IO_LANES{Q_MIN}}, 1'b1));
    send_term(term_of(16'sd0, {IO_LANES{16'sd0}}, 1'b1));
    drain();

    for (int i = 0; i < IO_LANES; i++) bset[i] = (i % 2) ? BIAS_MIN : BIAS_MAX;
    load_biases(bset);
    run_reductions(200);
    drain();

    for (int i = 0; i < IO_LANES; i++) bset[i] = bias_t'($urandom);
    load_biases(bset);
    run_reductions(150);
    // result side holds off while one-term reductions keep arriving
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 60; i++) send_term(rand_term(1'b1));
    run_reductions(150);
    drain();

    for (int i = 0; i < IO_LANES; i++) bset[i] = (i % 2) ? BIAS_MAX : BIAS_MIN;
    load_biases(bset);
    src_gaps = 1'b0;
    sink_stalls <= 1'b0;
    run_reductions(150);
    src_gaps = 1'b1;
    sink_stalls <= 1'b1;
    run_reductions(150);
    drain();

    for (int i = 0; i < IO_LANES; i++)
      bset[i] = bias_t'(int'($urandom_range(2097152)) - 1048576);
    load_biases(bset);
    run_reductions(200);
    drain();

    // lanes 0-3 grow positive, lanes 4-7 negative, all at full scale
    for (int i = 0; i < IO_LANES; i++) bset[i] = (i % 2) ? BIAS_MIN : BIAS_MAX;
    load_biases(bset);
    src_gaps = 1'b0;
    repeat (SAT_TERMS)
      send_term(term_of(Q_MIN, {Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0));
    // lanes 0,1 and 4,5 turn back, the rest keep growing
    send_term(term_of(Q_MIN, {Q_MAX, Q_MAX, Q_MIN, Q_MIN,
                              Q_MIN, Q_MIN, Q_MAX, Q_MAX}, 1'b0));
    send_term(term_of(Q_MIN, {Q_MAX, Q_MAX, Q_MIN, Q_MIN,
                              Q_MIN, Q_MIN, Q_MAX, Q_MAX}, 1'b1));
    src_gaps = 1'b1;
    drain();

    for (int i = 0; i < IO_LANES; i++) bset[i] = '0;
    load_biases(bset);
    run_reductions(150);
    drain();

    if (fail_count == 0) begin
      $display("conv_gemm_mac_tile test passed");
    end else begin
      $display("conv_gemm_mac_tile test failed");
    end
    $finish;
  end

endmodule
